// ===== hdl/asdm_pkg.sv =====
`default_nettype none

package asdm_pkg;

    // Field and datapath widths
    localparam int unsigned AXIS_W     = 16;
    localparam int unsigned MG_W       = 12;
    localparam int unsigned ABS_W      = 21;   // |count| * 61 stays below 2^21
    localparam int unsigned QUO_W      = 11;   // quotient and remainder stay below 2000
    localparam int unsigned PROD_W     = 33;   // ABS_W + 12-bit reciprocal
    localparam int unsigned SUM_W      = 24;   // three squares of 1998 stay below 2^24
    localparam int unsigned ROOT_W     = 12;
    localparam int unsigned PART_W     = 14;
    localparam int unsigned CFG_W      = 12;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned NUM_AXES   = 3;
    localparam int unsigned AXIS_SEL_W = 2;
    localparam int unsigned ROOT_STEPS = 12;
    localparam int unsigned STEP_W     = 4;
    localparam int unsigned READY_BIT  = 0;

    // Scale to milli-g: count * 61 / 1000
    localparam logic [6:0]  MG_NUM         = 7'd61;
    localparam logic [9:0]  MG_DEN         = 10'd1000;
    // floor(2^21 / 1000); the estimate is low by at most one
    localparam logic [11:0] MG_RECIP       = 12'd2097;
    localparam int unsigned MG_RECIP_SHIFT = 21;

    // Register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_ORDER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_LIMIT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_LIMIT = 2'd2;
    localparam logic                 AXIS_ORDER_RST = 1'b0;
    localparam logic [CFG_W-1:0]     LOW_LIMIT_RST  = 12'd800;
    localparam logic [CFG_W-1:0]     HIGH_LIMIT_RST = 12'd1200;

    typedef struct packed {
        logic [7:0] status_byte;
        logic [7:0] block_byte_0;
        logic [7:0] block_byte_1;
        logic [7:0] block_byte_2;
        logic [7:0] block_byte_3;
        logic [7:0] block_byte_4;
        logic [7:0] block_byte_5;
    } t_in_item;

    typedef struct packed {
        logic                     sample_ok;
        logic signed [AXIS_W-1:0] raw_x;
        logic signed [AXIS_W-1:0] raw_y;
        logic signed [AXIS_W-1:0] raw_z;
        logic signed [MG_W-1:0]   x_mg;
        logic signed [MG_W-1:0]   y_mg;
        logic signed [MG_W-1:0]   z_mg;
        logic [ROOT_W-1:0]        magnitude_mg;
        logic                     magnitude_bad;
    } t_out_item;

    typedef struct packed {
        logic             axis_order;
        logic [CFG_W-1:0] low_limit_mg;
        logic [CFG_W-1:0] high_limit_mg;
    } t_cfg;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SCALE,
        OP_RECIP,
        OP_REM,
        OP_FIX,
        OP_SQUARE,
        OP_ROOT,
        OP_PUBLISH
    } t_dp_op;

    typedef struct packed {
        t_dp_op                op;
        logic [AXIS_SEL_W-1:0] axis;
    } t_dp_cmd;

    typedef struct packed {
        logic new_data;
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== hdl/asdm_datapath.sv =====
`default_nettype none

module asdm_datapath import asdm_pkg::*; (
    input  wire logic      i_clk,
    input  wire t_dp_cmd   i_cmd,
    input  wire t_cfg      i_cfg,
    input  wire t_in_item  i_in_item,
    output t_dp_stat       o_stat,
    output t_out_item      o_out_item
);

    logic                     r_ok;
    logic signed [AXIS_W-1:0] r_raw [NUM_AXES];
    logic signed [MG_W-1:0]   r_mg  [NUM_AXES];
    logic                     r_neg;
    logic [ABS_W-1:0]         r_abs;
    logic [QUO_W-1:0]         r_quo;
    logic [QUO_W-1:0]         r_rem;
    logic [QUO_W-1:0]         r_fix;
    logic [SUM_W-1:0]         r_sum;
    logic [ROOT_W-1:0]        r_root;
    logic [PART_W-1:0]        r_part;
    t_out_item                r_out;

    logic [AXIS_W-1:0]        word_0;
    logic [AXIS_W-1:0]        word_1;
    logic [AXIS_W-1:0]        word_2;
    logic signed [AXIS_W-1:0] sel_raw;
    logic                     sel_neg;
    logic [AXIS_W-1:0]        sel_mag;
    logic [ABS_W-1:0]         scale_prod;
    logic [PROD_W-1:0]        recip_prod;
    logic [ABS_W-1:0]         rem_full;
    logic [QUO_W-1:0]         fix_q;
    logic [MG_W-1:0]          fix_ext;
    logic [MG_W-1:0]          fix_mg;
    logic [SUM_W-1:0]         square;
    logic [PART_W+1:0]        part_sh;
    logic [PART_W+1:0]        trial;
    logic [PART_W+1:0]        part_diff;
    logic                     root_ge;
    logic                     mag_bad;

    // Little-endian axis words
    assign word_0 = {i_in_item.block_byte_1, i_in_item.block_byte_0};
    assign word_1 = {i_in_item.block_byte_3, i_in_item.block_byte_2};
    assign word_2 = {i_in_item.block_byte_5, i_in_item.block_byte_4};

    // Magnitude and sign of the selected axis
    assign sel_raw    = r_raw[i_cmd.axis];
    assign sel_neg    = sel_raw[AXIS_W-1];
    assign sel_mag    = sel_neg ? (AXIS_W'(0) - AXIS_W'(sel_raw)) : AXIS_W'(sel_raw);
    assign scale_prod = ABS_W'(sel_mag) * ABS_W'(MG_NUM);

    // Divide by 1000: reciprocal estimate, then one correction step
    assign recip_prod = PROD_W'(r_abs) * PROD_W'(MG_RECIP);
    assign rem_full   = r_abs - ABS_W'(r_quo) * ABS_W'(MG_DEN);
    assign fix_q      = r_quo + QUO_W'(r_rem >= QUO_W'(MG_DEN));
    assign fix_ext    = {1'b0, fix_q};
    assign fix_mg     = r_neg ? (MG_W'(0) - fix_ext) : fix_ext;
    assign square     = SUM_W'(r_fix) * SUM_W'(r_fix);

    // One binary digit of the square root from two radicand bits
    assign part_sh   = {r_part, r_sum[SUM_W-1 -: 2]};
    assign trial     = {2'b00, r_root, 2'b01};
    assign root_ge   = part_sh >= trial;
    assign part_diff = part_sh - trial;

    assign mag_bad = (r_root < i_cfg.low_limit_mg) || (r_root > i_cfg.high_limit_mg);

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_ok     <= i_in_item.status_byte[READY_BIT];
                r_raw[0] <= i_cfg.axis_order ? word_2 : word_0;
                r_raw[1] <= word_1;
                r_raw[2] <= i_cfg.axis_order ? word_0 : word_2;
                r_sum    <= '0;
                r_root   <= '0;
                r_part   <= '0;
            end
            OP_SCALE: begin
                r_neg <= sel_neg;
                r_abs <= scale_prod;
            end
            OP_RECIP: begin
                r_quo <= recip_prod[MG_RECIP_SHIFT +: QUO_W];
            end
            OP_REM: begin
                r_rem <= rem_full[QUO_W-1:0];
            end
            OP_FIX: begin
                r_mg[i_cmd.axis] <= fix_mg;
                r_fix            <= fix_q;
            end
            OP_SQUARE: begin
                r_sum <= r_sum + square;
            end
            OP_ROOT: begin
                r_sum  <= {r_sum[SUM_W-3:0], 2'b00};
                r_root <= {r_root[ROOT_W-2:0], root_ge};
                r_part <= root_ge ? part_diff[PART_W-1:0] : part_sh[PART_W-1:0];
            end
            OP_PUBLISH: begin
                if (r_ok) begin
                    r_out.sample_ok     <= 1'b1;
                    r_out.raw_x         <= r_raw[0];
                    r_out.raw_y         <= r_raw[1];
                    r_out.raw_z         <= r_raw[2];
                    r_out.x_mg          <= r_mg[0];
                    r_out.y_mg          <= r_mg[1];
                    r_out.z_mg          <= r_mg[2];
                    r_out.magnitude_mg  <= r_root;
                    r_out.magnitude_bad <= mag_bad;
                end else begin
                    r_out <= '0;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_stat.new_data = r_ok;
    assign o_out_item      = r_out;

endmodule

`default_nettype wire

// ===== hdl/asdm_ctrl.sv =====
`default_nettype none

module asdm_ctrl import asdm_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  wire logic     i_out_stall,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCALE,
        S_RECIP,
        S_REM,
        S_FIX,
        S_SQUARE,
        S_ROOT,
        S_DONE
    } t_state;

    t_state                r_state;
    logic [AXIS_SEL_W-1:0] r_axis;
    logic [STEP_W-1:0]     r_step;
    logic                  r_out_valid;
    logic                  out_free;

    assign out_free   = !r_out_valid || !i_out_stall;
    // hold the input off while in reset and while an item is in work
    assign o_in_stall = !i_rst_n || (r_state != S_IDLE);

    always_comb begin
        o_cmd.axis = r_axis;
        case (r_state)
            S_IDLE:   o_cmd.op = i_in_valid ? OP_LOAD : OP_NONE;
            S_SCALE:  o_cmd.op = i_stat.new_data ? OP_SCALE : OP_NONE;
            S_RECIP:  o_cmd.op = OP_RECIP;
            S_REM:    o_cmd.op = OP_REM;
            S_FIX:    o_cmd.op = OP_FIX;
            S_SQUARE: o_cmd.op = OP_SQUARE;
            S_ROOT:   o_cmd.op = OP_ROOT;
            S_DONE:   o_cmd.op = out_free ? OP_PUBLISH : OP_NONE;
            default:  o_cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_axis      <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // drop the result once taken; in S_DONE the publish decides
            if (r_out_valid && !i_out_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_SCALE;
                        r_axis  <= '0;
                        r_step  <= '0;
                    end
                end
                S_SCALE: begin
                    r_state <= i_stat.new_data ? S_RECIP : S_DONE;
                end
                S_RECIP: r_state <= S_REM;
                S_REM:   r_state <= S_FIX;
                S_FIX:   r_state <= S_SQUARE;
                S_SQUARE: begin
                    if (r_axis == AXIS_SEL_W'(NUM_AXES - 1)) begin
                        r_state <= S_ROOT;
                    end else begin
                        r_axis  <= r_axis + AXIS_SEL_W'(1);
                        r_state <= S_SCALE;
                    end
                end
                S_ROOT: begin
                    r_step <= r_step + STEP_W'(1);
                    if (r_step == STEP_W'(ROOT_STEPS - 1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ===== hdl/accel_sample_decode_magnitude.sv =====
// Each sample is loaded, then each of its 3 axes takes 5 steps through the shared
// scale/square unit, the root takes 12 steps of one bit each, and the item is published;
// when status bit 0 is clear the item goes from the scale step straight to publish.
// A new item is taken only once the last is published, which waits on a stalled output.
// A finished item waits in the output register while the next one is taken.
// Reset: synchronous, active low; clears control and loads axis_order 0, limits 800/1200.
`default_nettype none

module accel_sample_decode_magnitude import asdm_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // input channel
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire t_in_item             i_in_item,
    // output channel
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output t_out_item                 o_out_item,
    // register write port
    input  wire logic                 i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_wdata
);

    t_cfg     r_cfg;
    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // Register file: writes beyond the list are dropped, extra data bits ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.axis_order    <= AXIS_ORDER_RST;
            r_cfg.low_limit_mg  <= LOW_LIMIT_RST;
            r_cfg.high_limit_mg <= HIGH_LIMIT_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_AXIS_ORDER: r_cfg.axis_order    <= i_cfg_wdata[0];
                REG_LOW_LIMIT:  r_cfg.low_limit_mg  <= i_cfg_wdata;
                REG_HIGH_LIMIT: r_cfg.high_limit_mg <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Sequencer: walks each item through load, per-axis scaling, root and publish (straight to publish if no new data).
    asdm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    // Datapath: axis assembly, divide by 1000, sum of squares, root, limit check,
    // and the output register that holds the item while it is stalled.
    asdm_datapath u_datapath (
        .i_clk      (i_clk),
        .i_cmd      (dp_cmd),
        .i_cfg      (r_cfg),
        .i_in_item  (i_in_item),
        .o_stat     (dp_stat),
        .o_out_item (o_out_item)
    );

endmodule

`default_nettype wire
